/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising edge of clk, off while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/adbd_pkg.sv */
// ---------------------------------------------------------------------------
// adbd_pkg
// Shared types, register indexes and decode tables for the ADPCM decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package adbd_pkg;

  // input word: one stream byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_t;

  // output word: one decoded sample or the end marker
  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               last;
    logic               phrase_done;
  } out_t;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_NIBBLE_FIRST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SIGN      = 1'd1;

  typedef struct packed {
    logic low_nibble_first;
    logic invert_sign;
  } cfg_t;

  // work item handed from parser to decoder
  typedef struct packed {
    logic       is_end;  // zero header: emit end marker
    logic       clr;     // phrase restart: clear step index and accumulator first
    logic [3:0] nib0;    // first code, already ordered and sign-adjusted
    logic [3:0] nib1;    // second code
  } job_t;

  // step size by [step index][code magnitude]
  localparam logic [7:0] STEP_MAG [16][8] = '{
    '{8'd0, 8'd0,  8'd1,  8'd2,  8'd3,  8'd5,   8'd7,   8'd10},
    '{8'd0, 8'd1,  8'd2,  8'd3,  8'd4,  8'd6,   8'd8,   8'd13},
    '{8'd0, 8'd1,  8'd2,  8'd4,  8'd5,  8'd7,   8'd10,  8'd15},
    '{8'd0, 8'd1,  8'd3,  8'd4,  8'd6,  8'd9,   8'd13,  8'd19},
    '{8'd0, 8'd2,  8'd3,  8'd5,  8'd8,  8'd11,  8'd15,  8'd23},
    '{8'd0, 8'd2,  8'd4,  8'd7,  8'd10, 8'd14,  8'd19,  8'd29},
    '{8'd0, 8'd3,  8'd5,  8'd8,  8'd12, 8'd16,  8'd22,  8'd33},
    '{8'd1, 8'd4,  8'd7,  8'd10, 8'd15, 8'd20,  8'd29,  8'd43},
    '{8'd1, 8'd4,  8'd8,  8'd13, 8'd18, 8'd25,  8'd35,  8'd53},
    '{8'd1, 8'd6,  8'd10, 8'd16, 8'd22, 8'd31,  8'd43,  8'd64},
    '{8'd2, 8'd7,  8'd12, 8'd19, 8'd27, 8'd37,  8'd51,  8'd76},
    '{8'd2, 8'd9,  8'd16, 8'd24, 8'd34, 8'd46,  8'd64,  8'd96},
    '{8'd3, 8'd11, 8'd19, 8'd29, 8'd41, 8'd57,  8'd79,  8'd117},
    '{8'd4, 8'd13, 8'd24, 8'd36, 8'd50, 8'd69,  8'd96,  8'd143},
    '{8'd4, 8'd16, 8'd29, 8'd44, 8'd62, 8'd85,  8'd118, 8'd175},
    '{8'd6, 8'd20, 8'd36, 8'd54, 8'd76, 8'd104, 8'd144, 8'd214}
  };

  // step index adjustment by code magnitude
  localparam logic signed [2:0] INDEX_MOVE [8] = '{
    -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd2, 3'sd3
  };

endpackage

/* rtl/adbd_front.sv */
// ---------------------------------------------------------------------------
// adbd_front
// Stream parser: classifies each byte and queues decode jobs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adbd_front #(
  parameter int FIXED_BLOCK_BYTES = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,      // input word accepted this cycle
  input  adbd_pkg::in_t word,
  input  adbd_pkg::cfg_t cfg,
  output logic          push,
  output adbd_pkg::job_t job
);
  import adbd_pkg::*;

  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_COUNT  = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;
  localparam logic [7:0] FIXED_LEN   = 8'(FIXED_BLOCK_BYTES);

  logic [1:0] mode, mode_next;
  logic [7:0] remain, remain_next;
  logic       finished, finished_next;
  logic       pend_clr;

  logic [1:0] mode_eff;
  logic [7:0] remain_eff;
  logic       fin_eff;
  logic [8:0] cnt_sum;
  logic [7:0] pairs;
  logic [3:0] hi, lo;
  logic       is_end, is_data;

  always_comb begin
    mode_eff   = word.start_req ? MODE_HEADER : mode;
    remain_eff = word.start_req ? 8'd0 : remain;
    fin_eff    = word.start_req ? 1'b0 : finished;
    cnt_sum    = {1'b0, word.data_byte} + 9'd1;
    pairs      = cnt_sum[8:1];
    hi = word.data_byte[7:4] ^ {cfg.invert_sign, 3'b000};
    lo = word.data_byte[3:0] ^ {cfg.invert_sign, 3'b000};

    mode_next     = mode_eff;
    remain_next   = remain_eff;
    finished_next = fin_eff;
    is_end        = 1'b0;
    is_data       = 1'b0;

    if (!fin_eff) begin
      unique case (mode_eff)
        MODE_COUNT: begin
          remain_next = pairs;
          mode_next   = (pairs != 8'd0) ? MODE_DATA : MODE_HEADER;
        end
        MODE_DATA: begin
          is_data     = 1'b1;
          remain_next = remain_eff - 8'd1;
          if (remain_next == 8'd0) begin
            mode_next = MODE_HEADER;
          end
        end
        default: begin
          mode_next = MODE_HEADER;
          if (word.data_byte == 8'd0) begin
            finished_next = 1'b1;
            is_end        = 1'b1;
          end else if (word.data_byte[6]) begin
            remain_next = FIXED_LEN;
            if (FIXED_LEN != 8'd0) begin
              mode_next = MODE_DATA;
            end
          end else if (word.data_byte[7]) begin
            mode_next = MODE_COUNT;
          end
        end
      endcase
    end

    push       = take && (is_end || is_data);
    job.is_end = is_end;
    job.clr    = pend_clr || word.start_req;
    job.nib0   = cfg.low_nibble_first ? lo : hi;
    job.nib1   = cfg.low_nibble_first ? hi : lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_HEADER;
      remain   <= 8'd0;
      finished <= 1'b0;
      pend_clr <= 1'b0;
    end else if (take) begin
      mode     <= mode_next;
      remain   <= remain_next;
      finished <= finished_next;
      // a restart that queues nothing rides on the next job
      if (push) begin
        pend_clr <= 1'b0;
      end else if (word.start_req) begin
        pend_clr <= 1'b1;
      end
    end
  end

endmodule

/* rtl/adbd_queue.sv */
// ---------------------------------------------------------------------------
// adbd_queue
// Two-entry job queue between the parser and the decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adbd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  adbd_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output adbd_pkg::job_t rd_job
);
  import adbd_pkg::*;

  localparam int DEPTH = 2;

  job_t       slot [DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'(DEPTH));
  assign avail  = (count != 2'd0);
  assign rd_job = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `ASSERT_CLK(a_no_overflow, !(push && full && !pop), "job queue overflow")
  `ASSERT_CLK(a_no_underflow, !(pop && !avail), "job queue underflow")
  `ASSERT_IMPL(a_ptr_gap, count == 2'd1, wr_ptr != rd_ptr, "queue pointers out of step")

endmodule

/* rtl/adbd_back.sv */
// ---------------------------------------------------------------------------
// adbd_back
// ADPCM decoder: runs queued jobs, one sample per cycle unless output is stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adbd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  adbd_pkg::job_t rd_job,
  output logic           pop,
  output logic           pcm_valid,
  input  logic           pcm_stall,
  output adbd_pkg::out_t pcm_word
);
  import adbd_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic       phase;     // 0: first nibble, 1: second nibble
  logic [3:0] step_idx, step_idx_next;
  logic [8:0] acc, acc_next;

  logic              out_ok, produce, done_now;
  logic [3:0]        code;
  logic [7:0]        mag;
  logic [8:0]        acc_new;
  logic signed [5:0] idx_sum;
  logic [3:0]        step_new;

  always_comb begin
    out_ok   = !pcm_valid || !pcm_stall;
    produce  = cur_valid && out_ok;
    done_now = produce && (cur.is_end || phase);
    pop      = avail && (!cur_valid || done_now);

    code    = phase ? cur.nib1 : cur.nib0;
    mag     = STEP_MAG[step_idx][code[2:0]];
    acc_new = code[3] ? (acc - {1'b0, mag}) : (acc + {1'b0, mag});
    idx_sum = $signed({2'b00, step_idx}) + {{3{INDEX_MOVE[code[2:0]][2]}},
                                            INDEX_MOVE[code[2:0]]};
    if (idx_sum[5]) begin
      step_new = 4'd0;
    end else if (idx_sum[4]) begin
      step_new = 4'd15;
    end else begin
      step_new = idx_sum[3:0];
    end

    acc_next      = acc;
    step_idx_next = step_idx;
    if (produce && !cur.is_end) begin
      acc_next      = acc_new;
      step_idx_next = step_new;
    end
    // restart wins over the last update of the previous phrase
    if (pop && rd_job.clr) begin
      acc_next      = 9'd0;
      step_idx_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
      step_idx  <= 4'd0;
      acc       <= 9'd0;
      pcm_valid <= 1'b0;
    end else begin
      if (produce) begin
        pcm_valid <= 1'b1;
      end else if (!pcm_stall) begin
        pcm_valid <= 1'b0;
      end

      acc      <= acc_next;
      step_idx <= step_idx_next;

      if (pop) begin
        cur_valid <= 1'b1;
        phase     <= 1'b0;
      end else if (done_now) begin
        cur_valid <= 1'b0;
        phase     <= 1'b0;
      end else if (produce) begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_job;
    end
    if (produce) begin
      if (cur.is_end) begin
        pcm_word.pcm_sample  <= 16'sd0;
        pcm_word.last        <= 1'b1;
        pcm_word.phrase_done <= 1'b1;
      end else begin
        pcm_word.pcm_sample  <= $signed({acc_new, 7'b0000000});
        pcm_word.last        <= phase;
        pcm_word.phrase_done <= 1'b0;
      end
    end
  end

  `ASSERT_IMPL(a_done_is_last, pcm_valid && pcm_word.phrase_done, pcm_word.last,
    "end marker without last")
  `ASSERT_IMPL(a_phase_busy, phase, cur_valid && !cur.is_end,
    "second nibble phase without a data job")
  `ASSERT_IMPL(a_hold_on_stall, $past(pcm_valid && pcm_stall) && !$past(rst),
    pcm_valid, "output word dropped while stalled")

endmodule

/* rtl/adpcm_block_stream_decoder_core.sv */
// ---------------------------------------------------------------------------
// adpcm_block_stream_decoder_core
// ADPCM block stream decoder: parses phrase bytes, emits 16-bit samples.
// ---------------------------------------------------------------------------
//
//   channel   dir  handshake                 payload
//   byte      in   byte_valid / byte_stall   byte_word (data_byte, start_req)
//   pcm       out  pcm_valid / pcm_stall     pcm_word (pcm_sample, last,
//                                                      phrase_done)
//   cfg       in   cfg_we                    cfg_index, cfg_data
//
// A data byte yields two samples in the decoder, decoded in turn, since each
// sample needs the accumulator and step index left by the one before.
// Header, count and ignored bytes are consumed by the parser and queue
// nothing; the end marker is a single decoder job.
// byte_stall is high only while the two-entry job queue is full.
// rst is synchronous; it clears parser, queue, decoder state and config.
// A stalled pcm word holds in the output register; the decoder waits behind
// it while the parser keeps filling the queue until it is full.
//
`timescale 1ns / 1ps

module adpcm_block_stream_decoder_core #(
  parameter int FIXED_BLOCK_BYTES = 128   // data bytes in a bit-6 block, 1..255
) (
  input  logic                             clk,
  input  logic                             rst,
  // byte stream in
  input  logic                             byte_valid,
  output logic                             byte_stall,
  input  adbd_pkg::in_t                    byte_word,
  // samples out
  output logic                             pcm_valid,
  input  logic                             pcm_stall,
  output adbd_pkg::out_t                   pcm_word,
  // register writes
  input  logic                             cfg_we,
  input  logic [adbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import adbd_pkg::*;

  cfg_t cfg;
  logic take;
  logic push, pop, full, avail;
  job_t wr_job, rd_job;

  // config registers; the user must write them only while the pipe is empty (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_NIBBLE_FIRST: cfg.low_nibble_first <= cfg_data[0];
        CFG_INVERT_SIGN:      cfg.invert_sign      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign byte_stall = full;
  assign take       = byte_valid && !byte_stall;

  // parser: tracks header/count/data mode, orders and flips nibbles
  adbd_front #(
    .FIXED_BLOCK_BYTES(FIXED_BLOCK_BYTES)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .word (byte_word),
    .cfg  (cfg),
    .push (push),
    .job  (wr_job)
  );

  adbd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .full   (full),
    .pop    (pop),
    .avail  (avail),
    .rd_job (rd_job)
  );

  // decoder: step table lookup, 9-bit wrapping accumulator, clamped index
  adbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .rd_job    (rd_job),
    .pop       (pop),
    .pcm_valid (pcm_valid),
    .pcm_stall (pcm_stall),
    .pcm_word  (pcm_word)
  );

endmodule

/* tb/adpcm_block_stream_decoder_core_test.sv */
// ---------------------------------------------------------------------------
// adpcm_block_stream_decoder_core_test
// Self-checking bench for the ADPCM block stream decoder. Phrase byte words
// go in with random gaps and pcm words come out under random stall. A
// scoreboard class tracks parser, step index and accumulator state and
// checks every sample word in order. Nibble order and sign flip are
// changed between phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adpcm_block_stream_decoder_core_test;
  import adbd_pkg::*;

  localparam int FIXED_BYTES  = 128;
  localparam int RANDOM_ITEMS = 1880;
  localparam int SETTLE_CYC   = 12;

  // step size by [step index][code magnitude]
  localparam logic [7:0] STEP_TBL [16][8] = '{
    '{8'd0, 8'd0,  8'd1,  8'd2,  8'd3,  8'd5,   8'd7,   8'd10},
    '{8'd0, 8'd1,  8'd2,  8'd3,  8'd4,  8'd6,   8'd8,   8'd13},
    '{8'd0, 8'd1,  8'd2,  8'd4,  8'd5,  8'd7,   8'd10,  8'd15},
    '{8'd0, 8'd1,  8'd3,  8'd4,  8'd6,  8'd9,   8'd13,  8'd19},
    '{8'd0, 8'd2,  8'd3,  8'd5,  8'd8,  8'd11,  8'd15,  8'd23},
    '{8'd0, 8'd2,  8'd4,  8'd7,  8'd10, 8'd14,  8'd19,  8'd29},
    '{8'd0, 8'd3,  8'd5,  8'd8,  8'd12, 8'd16,  8'd22,  8'd33},
    '{8'd1, 8'd4,  8'd7,  8'd10, 8'd15, 8'd20,  8'd29,  8'd43},
    '{8'd1, 8'd4,  8'd8,  8'd13, 8'd18, 8'd25,  8'd35,  8'd53},
    '{8'd1, 8'd6,  8'd10, 8'd16, 8'd22, 8'd31,  8'd43,  8'd64},
    '{8'd2, 8'd7,  8'd12, 8'd19, 8'd27, 8'd37,  8'd51,  8'd76},
    '{8'd2, 8'd9,  8'd16, 8'd24, 8'd34, 8'd46,  8'd64,  8'd96},
    '{8'd3, 8'd11, 8'd19, 8'd29, 8'd41, 8'd57,  8'd79,  8'd117},
    '{8'd4, 8'd13, 8'd24, 8'd36, 8'd50, 8'd69,  8'd96,  8'd143},
    '{8'd4, 8'd16, 8'd29, 8'd44, 8'd62, 8'd85,  8'd118, 8'd175},
    '{8'd6, 8'd20, 8'd36, 8'd54, 8'd76, 8'd104, 8'd144, 8'd214}
  };

  localparam int MOVE_TBL [8] = '{-1, -1, 0, 0, 1, 2, 2, 3};

  // Tracks decoder state and holds the sample words still owed by the block.
  class pcm_scoreboard;
    typedef enum logic [1:0] {PM_HEADER, PM_COUNT, PM_DATA} parse_mode_t;

    bit          low_first;
    bit          flip_sign;
    int          block_len;
    parse_mode_t mode;
    logic [7:0]  remaining;
    logic [3:0]  step_idx;
    logic [8:0]  acc;
    bit          done;
    out_t        sample_q[$];
    int          errors;

    function new(int fixed_bytes);
      block_len = fixed_bytes;
      low_first = 0;
      flip_sign = 0;
      errors    = 0;
      clear_phrase();
    endfunction

    function void clear_phrase();
      mode      = PM_HEADER;
      remaining = '0;
      step_idx  = '0;
      acc       = '0;
      done      = 0;
    endfunction

    function void set_config(bit lnf, bit fl);
      low_first = lnf;
      flip_sign = fl;
    endfunction

    function int pending();
      return sample_q.size();
    endfunction

    // one ADPCM code: move accumulator, then step index (clamped 0..15)
    function logic [15:0] advance_sample(logic [3:0] code);
      logic [8:0] mag;
      int         idx;
      mag = {1'b0, STEP_TBL[step_idx][code[2:0]]};
      if (code[3]) acc = acc - mag;
      else acc = acc + mag;
      idx = int'(step_idx) + MOVE_TBL[code[2:0]];
      if (idx < 0) idx = 0;
      if (idx > 15) idx = 15;
      step_idx = idx[3:0];
      return {acc, 7'b0};
    endfunction

    function void note_input(in_t w);
      logic [8:0] sum;
      logic [3:0] hi, lo, first, second;
      out_t       e;
      if (w.start_req) clear_phrase();
      if (done) return;
      case (mode)
        PM_COUNT: begin
          sum       = {1'b0, w.data_byte} + 9'd1;
          remaining = sum[8:1];
          mode      = (remaining != 0) ? PM_DATA : PM_HEADER;
        end
        PM_DATA: begin
          hi = w.data_byte[7:4];
          lo = w.data_byte[3:0];
          if (flip_sign) begin
            hi[3] = ~hi[3];
            lo[3] = ~lo[3];
          end
          first  = low_first ? lo : hi;
          second = low_first ? hi : lo;
          e.pcm_sample  = advance_sample(first);
          e.last        = 1'b0;
          e.phrase_done = 1'b0;
          sample_q = {sample_q, e};
          e.pcm_sample  = advance_sample(second);
          e.last        = 1'b1;
          sample_q = {sample_q, e};
          remaining = remaining - 8'd1;
          if (remaining == 0) mode = PM_HEADER;
        end
        default: begin
          mode = PM_HEADER;
          if (w.data_byte == 8'h00) begin
            done          = 1;
            e.pcm_sample  = '0;
            e.last        = 1'b1;
            e.phrase_done = 1'b1;
            sample_q = {sample_q, e};
          end else if (w.data_byte[6]) begin
            remaining = 8'(block_len);
            if (remaining != 0) mode = PM_DATA;
          end else if (w.data_byte[7]) begin
            mode = PM_COUNT;
          end
        end
      endcase
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (sample_q.size() == 0) begin
        $display("%0t: unexpected pcm word, expected none, got %h", $time, got);
        errors++;
        return;
      end
      e = sample_q.pop_front();
      if (got.pcm_sample !== e.pcm_sample) begin
        $display("%0t: pcm_sample mismatch, expected %0d, got %0d",
                 $time, e.pcm_sample, got.pcm_sample);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last mismatch, expected %b, got %b", $time, e.last, got.last);
        errors++;
      end
      if (got.phrase_done !== e.phrase_done) begin
        $display("%0t: phrase_done mismatch, expected %b, got %b",
                 $time, e.phrase_done, got.phrase_done);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  byte_valid;
  logic                  byte_stall;
  in_t                   byte_word;
  logic                  pcm_valid;
  logic                  pcm_stall = 1'b0;
  out_t                  pcm_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcm_scoreboard sb;
  int            items_sent;
  bit            no_gap_mode;
  int            stall_hold = 0;
  int            stall_pick;

  adpcm_block_stream_decoder_core #(
    .FIXED_BLOCK_BYTES(FIXED_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .pcm_valid  (pcm_valid),
    .pcm_stall  (pcm_stall),
    .pcm_word   (pcm_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Results are checked before the same edge's input is noted; a word
  // accepted at this edge cannot have produced a result yet.
  always @(posedge clk) begin
    if (!rst) begin
      if (pcm_valid && !pcm_stall) sb.check_result(pcm_word);
      if (byte_valid && !byte_stall) sb.note_input(byte_word);
    end
  end

  // Receiver: free-running stretches, short random stalls, a few long holds.
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 30) begin
        pcm_stall  <= 1'b0;
        stall_hold <= $urandom_range(10, 80);
      end else if (stall_pick < 92) begin
        pcm_stall  <= 1'($urandom_range(0, 1));
        stall_hold <= $urandom_range(0, 3);
      end else begin
        pcm_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end else begin
      stall_hold <= stall_hold - 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap_mode || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic st);
    in_t w;
    int  gap;
    w.data_byte = b;
    w.start_req = st;
    byte_word  <= w;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold the sender until every owed sample is out, then let the parser settle.
  task automatic drain();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_mode(input bit lnf, input bit fl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOW_NIBBLE_FIRST;
    cfg_data  <= lnf;
    @(negedge clk);
    cfg_index <= CFG_INVERT_SIGN;
    cfg_data  <= fl;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_config(lnf, fl);
  endtask

  // One phrase: mostly well-formed blocks with random data, plus ignored
  // headers, stray words, restarts mid-block and phrases with no end header.
  task automatic send_phrase();
    int         nblk;
    int         r;
    int         n;
    int         cut;
    logic [7:0] cnt;
    logic       st;
    no_gap_mode = ($urandom_range(0, 3) == 0);
    st   = 1'b1;
    nblk = $urandom_range(1, 6);
    for (int k = 0; k < nblk; k++) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        send_byte(8'h80 | 8'($urandom_range(0, 63)), st);
        st = 1'b0;
        r  = $urandom_range(0, 99);
        if (r < 80) cnt = 8'($urandom_range(0, 12));
        else if (r < 96) cnt = 8'($urandom_range(13, 60));
        else cnt = 8'($urandom_range(61, 255));
        send_byte(cnt, 1'b0);
        n = (int'(cnt) + 1) >> 1;
        repeat (n) send_byte(8'($urandom), 1'b0);
      end else if (r < 74) begin
        send_byte({1'($urandom), 1'b1, 6'($urandom)}, st);
        st = 1'b0;
        repeat (FIXED_BYTES) send_byte(8'($urandom), 1'b0);
      end else if (r < 86) begin
        send_byte(8'($urandom_range(1, 63)), st);
        st = 1'b0;
      end else if (r < 94) begin
        // broken block: header and count, part of the data, then a restart
        send_byte(8'h80 | 8'($urandom_range(0, 63)), st);
        cnt = 8'($urandom_range(6, 30));
        send_byte(cnt, 1'b0);
        cut = $urandom_range(0, ((int'(cnt) + 1) >> 1) - 1);
        repeat (cut) send_byte(8'($urandom), 1'b0);
        st = 1'b1;
      end else begin
        // stray word, start flag random
        send_byte(8'($urandom), 1'($urandom));
        st = 1'b0;
      end
    end
    if ($urandom_range(0, 99) < 85) begin
      send_byte(8'h00, st);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    byte_valid  = 1'b0;
    byte_word   = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    items_sent  = 0;
    no_gap_mode = 0;
    sb = new(FIXED_BYTES);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset config (high nibble first, no flip)
    send_byte(8'h80, 1'b1);   // variable block header opens the phrase
    send_byte(8'h00, 1'b0);   // count zero: empty block
    send_byte(8'hBF, 1'b0);
    send_byte(8'h05, 1'b0);   // three data words
    send_byte(8'h77, 1'b0);   // largest positive steps, drives accumulator wrap
    send_byte(8'h77, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h3F, 1'b0);   // ignored headers
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h03, 1'b0);   // two data words
    send_byte(8'hFF, 1'b0);
    send_byte(8'h88, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h07, 1'b0);   // four words announced, one sent
    send_byte(8'h0F, 1'b0);
    send_byte(8'h80, 1'b1);   // restart in the middle of a block
    send_byte(8'h01, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);   // end header
    send_byte(8'h40, 1'b0);   // words after the end are dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);   // phrase that ends at once

    // random phases, one per register setting
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_mode(ph == 0 || ph == 2, ph == 1 || ph == 2);
      while (items_sent < 23 + (ph + 1) * (RANDOM_ITEMS / 4)) begin
        send_phrase();
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("adpcm_block_stream_decoder_core_test: PASS");
    end else begin
      $display("adpcm_block_stream_decoder_core_test: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("adpcm_block_stream_decoder_core_test: FAIL");
    $finish;
  end

endmodule
